// ===== sv/lpsum_pkg.sv =====
// Package for the latency percentile summary block.
// Holds the sequencer state type, the chain control group and the rank constants.
// No dependencies.
package lpsum_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_EMIT
    } lpsum_state_t;

    // Control group broadcast to every cell of the chain
    typedef struct packed {
        logic ins_en;
        logic drain_en;
    } chain_ctrl_t;

    // Nearest-rank percentages and the rank step
    localparam int PCT_MEDIAN = 50;
    localparam int PCT_P95    = 95;
    localparam int PCT_P99    = 99;
    localparam int RANK_STEP  = 100;

endpackage

// ===== sv/lpsum_cell.sv =====
// One cell of the sorted insertion chain: holds a single sample.
// Depends on lpsum_pkg.
module lpsum_cell
    import lpsum_pkg::*;
#(
    parameter int SW = 48
)
(
    input  logic          clk,
    input  chain_ctrl_t   ctrl,
    input  logic          occupied,
    input  logic [SW-1:0] ins_val,
    input  logic [SW-1:0] left_val,
    input  logic          left_gt,
    input  logic [SW-1:0] right_val,
    output logic [SW-1:0] val,
    output logic          gt
);

    logic [SW-1:0] val_reg;
    logic [SW-1:0] val_next;

    // An empty cell counts as larger than any sample, so the new item lands at the end
    assign gt  = !occupied || (val_reg > ins_val);
    assign val = val_reg;

    // Insert: shift up from the left or take the new item; drain: take the right neighbour
    always_comb
    begin
        val_next = val_reg;
        if (ctrl.ins_en && gt)
        begin
            val_next = left_gt ? left_val : ins_val;
        end
        else if (ctrl.drain_en)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== sv/lpsum_chain.sv =====
// Row of lpsum_cell instances kept in ascending order; head is the smallest entry.
// Depends on lpsum_pkg and lpsum_cell.
module lpsum_chain
    import lpsum_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int SW    = 48,
    parameter int CW    = 9
)
(
    input  logic          clk,
    input  chain_ctrl_t   ctrl,
    input  logic [CW-1:0] count,
    input  logic [SW-1:0] ins_val,
    output logic [SW-1:0] head
);

    logic [SW-1:0] vals [DEPTH];
    logic          gts  [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [SW-1:0] lv;
            logic          lg;
            logic [SW-1:0] rv;

            // Neighbour wiring; the ends see the new item and their own value
            if (i == 0)
            begin : g_first
                assign lv = ins_val;
                assign lg = 1'b0;
            end
            else
            begin : g_mid
                assign lv = vals[i-1];
                assign lg = gts[i-1];
            end

            if (i == DEPTH-1)
            begin : g_last
                assign rv = vals[i];
            end
            else
            begin : g_inner
                assign rv = vals[i+1];
            end

            lpsum_cell #(
                .SW (SW)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (CW'(i) < count),
                .ins_val   (ins_val),
                .left_val  (lv),
                .left_gt   (lg),
                .right_val (rv),
                .val       (vals[i]),
                .gt        (gts[i])
            );
        end
    endgenerate

    assign head = vals[0];

endmodule

// ===== sv/lpsum_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle until all DW bits are formed.
// No dependencies.
module lpsum_div
#(
    parameter int DW = 57,
    parameter int VW = 9
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DW-1:0]    quo_reg;
    logic [DW-1:0]    quo_next;
    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    rem_next;
    logic [VW:0]      rem_sh;
    logic [VW:0]      rem_sub;
    logic             q_bit;

    assign done     = (cnt_reg == CNT_W'(DW));
    assign quotient = quo_reg;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DW-1]};
        rem_sub  = rem_sh - {1'b0, divisor};
        q_bit    = (rem_sh >= {1'b0, divisor});
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
        end
        else if (!done)
        begin
            cnt_next = cnt_reg + 1'b1;
            quo_next = {quo_reg[DW-2:0], q_bit};
            rem_next = q_bit ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_W'(DW);
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule

// ===== sv/latency_percentile_summary.sv =====
// Latency percentile summary: count, min, median, p95, p99, max and mean of a run.
// Depends on lpsum_pkg, lpsum_chain (lpsum_cell) and lpsum_div.
//
// Input channel s_*: one duration sample per item in s_tdata, s_tuser flags that the
// sample is valid, s_tlast closes the run. Ordinary items are accepted while idle and
// are sorted into a chain of MAX_SAMPLES cells as they arrive; samples beyond capacity
// are discarded and reported in the dropped flag.
// Output channel m_*: one summary item per closed run. m_tuser carries the dropped flag.
// An empty run gives an all-zero summary.
// After a closing item the input stalls while the chain drains one sample per cycle
// past the rank compares and the bit-serial divider forms the mean. The result then
// sits in the output register and the input reopens.
// If the receiver stalls, the result register holds and a second closing item waits
// at the end of its summary until the previous result has been taken.
// Reset clears the run (count, sum, dropped flag) and the output valid.
module latency_percentile_summary
    import lpsum_pkg::*;
#(
    parameter int MAX_SAMPLES  = 256,
    parameter int SAMPLE_WIDTH = 48
)
(
    input  logic clk,
    input  logic rst_n,
    // s_tdata: [SAMPLE_WIDTH-1:0] sample_value, zero padded to bytes
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic s_tuser,   // has_sample
    input  logic s_tlast,   // last_item
    input  logic s_tvalid,
    output logic s_tready,
    // m_tdata from bit 0: sample_count, minimum_value, median_value, p95_value,
    // p99_value, maximum_value, mean_value, zero padded to bytes
    output logic [(($clog2(MAX_SAMPLES+1)+6*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic m_tuser,   // dropped_flag
    output logic m_tvalid,
    input  logic m_tready
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SUMW  = SW + CW;
    localparam int AW    = CW + 7;
    localparam int OUT_W = ((CW + 6*SW + 7) / 8) * 8;

    lpsum_state_t  state_reg;
    lpsum_state_t  state_next;
    chain_ctrl_t   ctrl;
    logic          div_start;
    logic          emit_load;
    logic          div_done;
    logic [SUMW-1:0] quotient;
    logic [SW-1:0] head;
    logic [SW-1:0] sample;

    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [SUMW-1:0] sum_reg;
    logic [SUMW-1:0] sum_next;
    logic            ovf_reg;
    logic            ovf_next;
    logic [CW-1:0]   k_reg;
    logic [CW-1:0]   k_next;
    logic [AW-1:0]   acc_reg;
    logic [AW-1:0]   acc_next;
    logic [AW-1:0]   tgt_med_reg;
    logic [AW-1:0]   tgt_p95_reg;
    logic [AW-1:0]   tgt_p99_reg;
    logic            got_med_reg;
    logic            got_med_next;
    logic            got_p95_reg;
    logic            got_p95_next;
    logic            got_p99_reg;
    logic            got_p99_next;
    logic [SW-1:0]   min_reg;
    logic [SW-1:0]   med_reg;
    logic [SW-1:0]   p95_reg;
    logic [SW-1:0]   p99_reg;
    logic [SW-1:0]   max_reg;
    logic            m_valid_reg;
    logic            m_valid_next;
    logic [OUT_W-1:0] m_data_reg;
    logic            m_user_reg;
    logic            draining;
    logic            room;

    assign sample   = s_tdata[SW-1:0];
    assign room     = (count_reg < CW'(MAX_SAMPLES));
    assign draining = (k_reg < count_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (!draining && div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready      = 1'b0;
        ctrl.ins_en   = 1'b0;
        ctrl.drain_en = 1'b0;
        div_start     = 1'b0;
        emit_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                ctrl.ins_en = s_tvalid && s_tuser && room;
            end
            ST_PREP:
            begin
                div_start = 1'b1;
            end
            ST_RUN:
            begin
                ctrl.drain_en = draining;
            end
            ST_EMIT:
            begin
                emit_load = !m_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    lpsum_chain #(
        .DEPTH (MAX_SAMPLES),
        .SW    (SW),
        .CW    (CW)
    ) u_chain (
        .clk     (clk),
        .ctrl    (ctrl),
        .count   (count_reg),
        .ins_val (sample),
        .head    (head)
    );

    lpsum_div #(
        .DW (SUMW),
        .VW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Run bookkeeping and drain-side rank tracking
    always_comb
    begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        ovf_next     = ovf_reg;
        k_next       = k_reg;
        acc_next     = acc_reg;
        got_med_next = got_med_reg;
        got_p95_next = got_p95_reg;
        got_p99_next = got_p99_reg;
        if (ctrl.ins_en)
        begin
            count_next = count_reg + 1'b1;
            sum_next   = sum_reg + SUMW'(sample);
        end
        else if (state_reg == ST_IDLE && s_tvalid && s_tuser)
        begin
            ovf_next = 1'b1;
        end
        if (div_start)
        begin
            k_next       = '0;
            acc_next     = AW'(RANK_STEP);
            got_med_next = 1'b0;
            got_p95_next = 1'b0;
            got_p99_next = 1'b0;
        end
        else if (ctrl.drain_en)
        begin
            k_next   = k_reg + 1'b1;
            acc_next = acc_reg + AW'(RANK_STEP);
            if (acc_reg >= tgt_med_reg)
            begin
                got_med_next = 1'b1;
            end
            if (acc_reg >= tgt_p95_reg)
            begin
                got_p95_next = 1'b1;
            end
            if (acc_reg >= tgt_p99_reg)
            begin
                got_p99_next = 1'b1;
            end
        end
        if (emit_load)
        begin
            count_next = '0;
            sum_next   = '0;
            ovf_next   = 1'b0;
        end
    end

    // Output register: load on emit, clear when taken
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (emit_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            k_reg       <= '0;
            acc_reg     <= '0;
            got_med_reg <= 1'b0;
            got_p95_reg <= 1'b0;
            got_p99_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            ovf_reg     <= ovf_next;
            k_reg       <= k_next;
            acc_reg     <= acc_next;
            got_med_reg <= got_med_next;
            got_p95_reg <= got_p95_next;
            got_p99_reg <= got_p99_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Rank targets pct*n and captures from the chain head; 100*(k+1) >= pct*n picks rank k
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            tgt_med_reg <= AW'(count_reg) * AW'(PCT_MEDIAN);
            tgt_p95_reg <= AW'(count_reg) * AW'(PCT_P95);
            tgt_p99_reg <= AW'(count_reg) * AW'(PCT_P99);
        end
        if (ctrl.drain_en)
        begin
            if (k_reg == '0)
            begin
                min_reg <= head;
            end
            if (k_reg + 1'b1 == count_reg)
            begin
                max_reg <= head;
            end
            if (!got_med_reg && acc_reg >= tgt_med_reg)
            begin
                med_reg <= head;
            end
            if (!got_p95_reg && acc_reg >= tgt_p95_reg)
            begin
                p95_reg <= head;
            end
            if (!got_p99_reg && acc_reg >= tgt_p99_reg)
            begin
                p99_reg <= head;
            end
        end
        if (emit_load)
        begin
            if (count_reg == '0)
            begin
                m_data_reg <= '0;
                m_user_reg <= 1'b0;
            end
            else
            begin
                m_data_reg <= OUT_W'({quotient[SW-1:0], max_reg, p99_reg, p95_reg,
                                      med_reg, min_reg, count_reg});
                m_user_reg <= ovf_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== sv/lpsum_checker.sv =====
// Port-level checks for latency_percentile_summary, attached by bind.
// Depends on the top level's port list only.
module lpsum_checker
#(
    parameter int MAX_SAMPLES  = 256,
    parameter int SAMPLE_WIDTH = 48
)
(
    input logic clk,
    input logic rst_n,
    input logic s_tlast,
    input logic s_tvalid,
    input logic s_tready,
    input logic [(($clog2(MAX_SAMPLES+1)+6*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
    input logic m_tuser,
    input logic m_tvalid,
    input logic m_tready
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic [CW-1:0] cnt;
    logic [SW-1:0] f_min;
    logic [SW-1:0] f_med;
    logic [SW-1:0] f_p95;
    logic [SW-1:0] f_p99;
    logic [SW-1:0] f_max;
    logic [SW-1:0] f_mean;

    assign cnt    = m_tdata[CW-1:0];
    assign f_min  = m_tdata[CW+SW-1:CW];
    assign f_med  = m_tdata[CW+2*SW-1:CW+SW];
    assign f_p95  = m_tdata[CW+3*SW-1:CW+2*SW];
    assign f_p99  = m_tdata[CW+4*SW-1:CW+3*SW];
    assign f_max  = m_tdata[CW+5*SW-1:CW+4*SW];
    assign f_mean = m_tdata[CW+6*SW-1:CW+5*SW];

    // A stalled summary item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("summary item changed while stalled");

    // A closing item starts the summary, so the input closes for the next cycle
    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input accepted during summary");

    // An empty run reports zeros throughout
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && cnt == '0 |-> m_tdata[CW+6*SW-1:CW] == '0 && !m_tuser)
        else $error("empty run gave a non-zero summary");

    // Order statistics and mean stay in order, count within capacity
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && cnt != '0 |-> cnt <= CW'(MAX_SAMPLES) && f_min <= f_med
            && f_med <= f_p95 && f_p95 <= f_p99 && f_p99 <= f_max
            && f_min <= f_mean && f_mean <= f_max)
        else $error("summary fields out of order");

endmodule

bind latency_percentile_summary lpsum_checker #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_lpsum_checker (.*);
